// ===== rtl/core/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg
// Shared constants, types and helpers for the cubic spline point evaluator.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int COORD_BITS     = 24;
    localparam int FRAC_BITS      = 16;
    localparam int PARAM_BITS     = 25;
    localparam int INDEX_BITS     = 6;
    localparam int COUNT_BITS     = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MAX_POINTS_DEF = 64;

    // integer part of t
    localparam int TINT_BITS  = PARAM_BITS - 1 - FRAC_BITS;
    // fraction values 0..one
    localparam int FW         = FRAC_BITS + 1;
    // signed weight, up to 4*one
    localparam int WW         = FRAC_BITS + 4;
    // signed prescaled point, up to 6*p + 2*p
    localparam int PW         = COORD_BITS + 4;
    localparam int PRODW      = PW + WW;
    localparam int ACCW       = PRODW + 2;
    localparam int POINT_BITS = 3 * COORD_BITS;

    // final divide by 3 on a biased nonnegative value
    localparam int ZW          = COORD_BITS + 4;
    localparam int BIAS_SHIFT  = COORD_BITS + 2;
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
    localparam int RECIP_SHIFT = 33;

    localparam logic [FW-1:0] ONE  = FW'(1) << FRAC_BITS;
    localparam logic [FW-1:0] HALF = FW'(1) << (FRAC_BITS - 1);

    localparam logic ACT_WRITE     = 1'b0;
    localparam logic ACT_EVAL      = 1'b1;
    localparam logic MODE_CATMULL  = 1'b0;
    localparam logic MODE_BSPLINE  = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_POINT_COUNT  = 2'd0,
        CFG_SPLINE_MODE  = 2'd1,
        CFG_CLOSED_CURVE = 2'd2
    } t_cfg_index;

    // rounded product of two fraction values
    function automatic logic [FW-1:0] fmul(input logic [FW-1:0] a, input logic [FW-1:0] b);
        logic [2*FW-1:0] p;
        p = (2*FW)'(a) * (2*FW)'(b) + (2*FW)'(HALF);
        return p[FRAC_BITS +: FW];
    endfunction

endpackage

// ===== rtl/core/csp_ram.sv =====
// ----------------------------------------------------------------------------
// csp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module csp_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/csp_seg.sv =====
// ----------------------------------------------------------------------------
// csp_seg
// Segment selection: clamps t, picks the segment and fraction, and forms the
// four wrapped control point addresses.
// ----------------------------------------------------------------------------
module csp_seg #(
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic [csp_pkg::PARAM_BITS-1:0] i_curve_param,
    input  logic [CW-1:0]                  i_count,
    input  logic                           i_mode,
    input  logic                           i_closed,
    output logic [csp_pkg::FW-1:0]         o_u,
    output logic [AW-1:0]                  o_addr [4]
);

    import csp_pkg::*;

    localparam int IW = ((CW > TINT_BITS) ? CW : TINT_BITS) + 2;

    logic signed [IW-1:0] n_s;
    logic signed [IW-1:0] idx;
    logic signed [IW-1:0] s_k;
    logic [TINT_BITS-1:0] t_int;
    logic [FRAC_BITS-1:0] t_frac;
    logic [FW-1:0]        u;

    always_comb begin
        n_s = IW'(i_count);
        if (i_curve_param[PARAM_BITS-1]) begin
            t_int  = '0;
            t_frac = '0;
        end else begin
            t_int  = i_curve_param[PARAM_BITS-2:FRAC_BITS];
            t_frac = i_curve_param[FRAC_BITS-1:0];
        end
        idx = IW'(t_int);
        u   = FW'(t_frac);
        // past the end: last segment at fraction one
        if (idx >= n_s) begin
            idx = n_s - IW'(1);
            u   = ONE;
        end
        if (i_mode == MODE_CATMULL && !i_closed) begin
            if (idx < IW'(1)) begin
                idx = IW'(1);
                u   = '0;
            end else if (idx >= n_s - IW'(2)) begin
                idx = n_s - IW'(3);
                u   = ONE;
            end
        end
        o_u = u;
        for (int k = 0; k < 4; k++) begin
            s_k = idx + IW'(k) - IW'(i_mode == MODE_CATMULL);
            if (s_k < 0) begin
                s_k = s_k + n_s;
            end else if (s_k >= n_s) begin
                s_k = s_k - n_s;
            end
            o_addr[k] = s_k[AW-1:0];
        end
    end

endmodule

// ===== rtl/core/csp_weight.sv =====
// ----------------------------------------------------------------------------
// csp_weight
// Three stage pipeline forming the four blend weights from the fraction u.
// ----------------------------------------------------------------------------
module csp_weight (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [csp_pkg::FW-1:0]        i_u,
    input  logic                          i_mode,
    output logic signed [csp_pkg::WW-1:0] o_w [4]
);

    import csp_pkg::*;

    localparam logic signed [WW-1:0] ONE_W = WW'(ONE);

    logic [FW-1:0] r_s2_u, r_s2_v, r_s2_u2, r_s2_v2;
    logic          r_s2_mode;
    logic [FW-1:0] r_s3_u, r_s3_u2, r_s3_u3, r_s3_v3, r_s3_uv2, r_s3_u2v;
    logic          r_s3_mode;
    logic signed [WW-1:0] r_w [4];
    logic signed [WW-1:0] n_w [4];
    logic [FW-1:0] n_v;
    logic signed [WW-1:0] e_u, e_u2, e_u3;

    assign n_v = ONE - i_u;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_u    <= i_u;
            r_s2_v    <= n_v;
            r_s2_u2   <= fmul(i_u, i_u);
            r_s2_v2   <= fmul(n_v, n_v);
            r_s2_mode <= i_mode;
            r_s3_u    <= r_s2_u;
            r_s3_u2   <= r_s2_u2;
            r_s3_u3   <= fmul(r_s2_u2, r_s2_u);
            r_s3_v3   <= fmul(r_s2_v2, r_s2_v);
            r_s3_uv2  <= fmul(r_s2_u, r_s2_v2);
            r_s3_u2v  <= fmul(r_s2_u2, r_s2_v);
            r_s3_mode <= r_s2_mode;
            r_w       <= n_w;
        end
    end

    always_comb begin
        e_u    = WW'(r_s3_u);
        e_u2   = WW'(r_s3_u2);
        e_u3   = WW'(r_s3_u3);
        n_w[0] = WW'(r_s3_v3);
        n_w[3] = e_u3;
        if (r_s3_mode == MODE_BSPLINE) begin
            n_w[1] = WW'(3 * e_u3 - 6 * e_u2 + 4 * ONE_W);
            n_w[2] = WW'(-3 * e_u3 + 3 * e_u2 + 3 * e_u + ONE_W);
        end else begin
            n_w[1] = WW'(3 * r_s3_uv2);
            n_w[2] = WW'(3 * r_s3_u2v);
        end
    end

    assign o_w = r_w;

endmodule

// ===== rtl/core/csp_blend.sv =====
// ----------------------------------------------------------------------------
// csp_blend
// Prescales the four control points in catmull-rom mode, multiplies by the weights, sums, and
// divides by 6*one with rounding and saturation.
// ----------------------------------------------------------------------------
module csp_blend (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic                                i_mode,
    input  logic [csp_pkg::POINT_BITS-1:0]      i_pt [4],
    input  logic signed [csp_pkg::WW-1:0]       i_w [4],
    output logic signed [csp_pkg::COORD_BITS-1:0] o_coord [3]
);

    import csp_pkg::*;

    localparam logic signed [ACCW-1:0] RND_ACC = ACCW'(3) << FRAC_BITS;
    localparam logic signed [ACCW-FRAC_BITS-1:0] BIAS_Z =
        (ACCW-FRAC_BITS)'(3) << BIAS_SHIFT;
    localparam logic signed [ZW:0] BIAS_Q = (ZW+1)'(1) << BIAS_SHIFT;
    localparam logic signed [ZW:0] SAT_HI = (ZW+1)'((1 << (COORD_BITS-1)) - 1);
    localparam logic signed [ZW:0] SAT_LO = -SAT_HI - (ZW+1)'(1);

    logic signed [PW-1:0]    n_c [4][3];
    logic signed [PW-1:0]    r_c2 [4][3];
    logic signed [PW-1:0]    r_c3 [4][3];
    logic signed [PW-1:0]    r_c4 [4][3];
    logic signed [PRODW-1:0] r_prod [4][3];
    logic [ZW-1:0]           r_z [3];
    logic [ZW-2:0]           r_q [3];
    logic signed [PW-1:0]    p [4];
    logic signed [ACCW-1:0]  acc [3];
    logic signed [ACCW-FRAC_BITS-1:0] y [3];
    logic [ZW+31:0]          m [3];
    logic signed [ZW:0]      r_res [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
                p[k] = PW'($signed(i_pt[k][c*COORD_BITS +: COORD_BITS]));
            end
            if (i_mode == MODE_BSPLINE) begin
                for (int k = 0; k < 4; k++) begin
                    n_c[k][c] = p[k];
                end
            end else begin
                n_c[0][c] = PW'(6 * p[1]);
                n_c[1][c] = PW'(6 * p[1] + p[2] - p[0]);
                n_c[2][c] = PW'(6 * p[2] - p[3] + p[1]);
                n_c[3][c] = PW'(6 * p[2]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = ACCW'(r_prod[0][c]) + ACCW'(r_prod[1][c]) + ACCW'(r_prod[2][c])
                   + ACCW'(r_prod[3][c]) + RND_ACC;
            // floor by 2*one, then a biased floor by 3
            y[c]   = (ACCW-FRAC_BITS)'(acc[c] >>> (FRAC_BITS + 1)) + BIAS_Z;
            m[c]   = (ZW+32)'(r_z[c]) * (ZW+32)'(RECIP3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c2 <= n_c;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 4; k++) begin
                    r_prod[k][c] <= PRODW'(r_c4[k][c] * i_w[k]);
                end
                r_z[c] <= y[c][ZW-1:0];
                r_q[c] <= m[c][RECIP_SHIFT +: ZW-1];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            r_res[c] = $signed({2'b00, r_q[c]}) - BIAS_Q;
            if (r_res[c] > SAT_HI) begin
                o_coord[c] = SAT_HI[COORD_BITS-1:0];
            end else if (r_res[c] < SAT_LO) begin
                o_coord[c] = SAT_LO[COORD_BITS-1:0];
            end else begin
                o_coord[c] = r_res[c][COORD_BITS-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/cubic_spline_point_evaluator.sv =====
// throughput: one request per cycle unless the output stalls, writes and evaluates alike
// the four point reads per evaluate come from four copies of the point memory
// stall on the output freezes the whole pipeline
// reset: configuration to 4 points, catmull-rom, open; pipeline emptied
// point memory is not cleared and is undefined until written
// ----------------------------------------------------------------------------
// cubic_spline_point_evaluator
// Evaluates uniform catmull-rom or cubic b-spline curves over a table of 3d
// control points held in on-chip memory.
// ----------------------------------------------------------------------------
module cubic_spline_point_evaluator #(
    parameter int MAX_POINTS = csp_pkg::MAX_POINTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [csp_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [csp_pkg::COUNT_BITS-1:0]        i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_action,
    input  logic [csp_pkg::INDEX_BITS-1:0]        i_point_index,
    input  logic signed [csp_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [csp_pkg::COORD_BITS-1:0] i_point_y,
    input  logic signed [csp_pkg::COORD_BITS-1:0] i_point_z,
    input  logic signed [csp_pkg::PARAM_BITS-1:0] i_curve_param,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [csp_pkg::COORD_BITS-1:0] o_curve_x,
    output logic signed [csp_pkg::COORD_BITS-1:0] o_curve_y,
    output logic signed [csp_pkg::COORD_BITS-1:0] o_curve_z
);

    import csp_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = ($clog2(MAX_POINTS + 1) > COUNT_BITS) ?
                        $clog2(MAX_POINTS + 1) : COUNT_BITS;
    localparam int DEPTH_VLD = 7;

    logic [COUNT_BITS-1:0] r_point_count;
    logic                  r_spline_mode;
    logic                  r_closed_curve;
    logic [DEPTH_VLD-1:0]  r_vld;
    logic                  r_o_valid;
    logic [FW-1:0]         r_u;
    logic                  r_mode;
    logic [COORD_BITS-1:0] r_x, r_y, r_z;

    logic [CW-1:0]         n_count;
    logic [CW-1:0]         pc_w;
    logic                  adv, accept, do_eval, do_write;
    logic [FW-1:0]         seg_u;
    logic [AW-1:0]         seg_addr [4];
    logic [AW-1:0]         waddr;
    logic [POINT_BITS-1:0] rdata [4];
    logic signed [WW-1:0]  w [4];
    logic signed [COORD_BITS-1:0] coord [3];

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count  <= COUNT_BITS'(4);
            r_spline_mode  <= MODE_CATMULL;
            r_closed_curve <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POINT_COUNT:  r_point_count  <= i_cfg_data;
                CFG_SPLINE_MODE:  r_spline_mode  <= i_cfg_data[0];
                CFG_CLOSED_CURVE: r_closed_curve <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pc_w = CW'(r_point_count);
        if (pc_w < CW'(4)) begin
            n_count = CW'(4);
        end else if (pc_w > CW'(MAX_POINTS)) begin
            n_count = CW'(MAX_POINTS);
        end else begin
            n_count = pc_w;
        end
    end

    assign adv      = !r_o_valid || i_ready;
    assign o_ready  = adv;
    assign accept   = i_valid && adv;
    assign do_eval  = accept && (i_action == ACT_EVAL);
    assign do_write = accept && (i_action == ACT_WRITE) &&
                      (32'(i_point_index) < 32'(MAX_POINTS));
    assign waddr    = AW'(i_point_index);

    csp_seg #(
        .AW (AW),
        .CW (CW)
    ) u_seg (
        .i_curve_param (i_curve_param),
        .i_count       (n_count),
        .i_mode        (r_spline_mode),
        .i_closed      (r_closed_curve),
        .o_u           (seg_u),
        .o_addr        (seg_addr)
    );

    // one copy of the point table per read tap
    for (genvar g = 0; g < 4; g++) begin : g_mem
        csp_ram #(
            .WIDTH (POINT_BITS),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (do_write),
            .i_waddr (waddr),
            .i_wdata ({i_point_z, i_point_y, i_point_x}),
            .i_re    (do_eval),
            .i_raddr (seg_addr[g]),
            .o_rdata (rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[DEPTH_VLD-2:0], do_eval};
            r_o_valid <= r_vld[DEPTH_VLD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (do_eval) begin
                r_u    <= seg_u;
                r_mode <= r_spline_mode;
            end
            if (r_vld[DEPTH_VLD-1]) begin
                r_x <= coord[0];
                r_y <= coord[1];
                r_z <= coord[2];
            end
        end
    end

    csp_weight u_weight (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_u    (r_u),
        .i_mode (r_mode),
        .o_w    (w)
    );

    csp_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_mode  (r_mode),
        .i_pt    (rdata),
        .i_w     (w),
        .o_coord (coord)
    );

    assign o_valid   = r_o_valid;
    assign o_curve_x = r_x;
    assign o_curve_y = r_y;
    assign o_curve_z = r_z;

endmodule

// ===== rtl/core/csp_checker.sv =====
// ----------------------------------------------------------------------------
// csp_checker
// Port level checks for the cubic spline point evaluator.
// ----------------------------------------------------------------------------
module csp_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_ready,
    input  logic                                  o_valid,
    input  logic                                  i_ready,
    input  logic signed [csp_pkg::COORD_BITS-1:0] o_curve_x,
    input  logic signed [csp_pkg::COORD_BITS-1:0] o_curve_y,
    input  logic signed [csp_pkg::COORD_BITS-1:0] o_curve_z
);

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("o_valid set after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_curve_x) &&
        $stable(o_curve_y) && $stable(o_curve_z))
        else $error("stalled result changed");

    // an empty output never blocks requests
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request blocked with empty output");

    // a taken result frees the pipeline
    a_taken_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |-> o_ready)
        else $error("request blocked while result taken");

    // a new result only appears on a cycle the pipeline moved
    a_rise_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_ready))
        else $error("result appeared without pipeline advance");

endmodule

bind cubic_spline_point_evaluator csp_checker u_csp_checker (.*);
